>>> hdl/pfpc_pkg.sv
`timescale 1ns / 1ps

package pfpc_pkg;

  localparam int IN_W       = 24;
  localparam int OUT_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_RECOVER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SAVE_DELAY   = 3'd7;

  localparam logic [11:0] RST_TEMP_TRIP    = 12'd2089;
  localparam logic [11:0] RST_TEMP_RECOVER = 12'd1720;
  localparam logic [9:0]  RST_VOLTAGE_STEP = 10'd50;
  localparam logic [15:0] RST_VOLTAGE_MAX  = 16'd24000;
  localparam logic [9:0]  RST_CURRENT_STEP = 10'd5;
  localparam logic [15:0] RST_CURRENT_MAX  = 16'd2000;
  localparam logic [7:0]  RST_LONG_PRESS   = 8'd20;
  localparam logic [7:0]  RST_SAVE_DELAY   = 8'd100;

  localparam logic [15:0] RST_VOLTAGE_SET = 16'd3300;
  localparam logic [15:0] RST_CURRENT_SET = 16'd100;

  localparam logic [4:0]  HOLD_TICKS = 5'd20;
  localparam logic [13:0] VDAC_GAIN  = 14'd10600;
  localparam logic [14:0] IDAC_GAIN  = 15'd16500;
  localparam logic [11:0] DAC_FULL   = 12'd4095;
  localparam int          FLASH_BIT  = 3;

  typedef struct packed {
    logic [11:0] temp_trip;
    logic [11:0] temp_recover;
    logic [9:0]  voltage_step;
    logic [15:0] voltage_max;
    logic [9:0]  current_step;
    logic [15:0] current_max;
    logic [7:0]  long_press;
    logic [7:0]  save_delay;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic edit;
    logic dac;
    logic out_load;
  } cmd_t;

  function automatic logic [11:0] dac_sat(input logic [14:0] v);
    logic [11:0] r;
    if (v > {3'd0, DAC_FULL}) begin
      r = DAC_FULL;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/pfpc_cfg.sv
`timescale 1ns / 1ps

module pfpc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output pfpc_pkg::cfg_t                  cfg
);
  import pfpc_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = rst_n;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_trip    <= RST_TEMP_TRIP;
      cfg_r.temp_recover <= RST_TEMP_RECOVER;
      cfg_r.voltage_step <= RST_VOLTAGE_STEP;
      cfg_r.voltage_max  <= RST_VOLTAGE_MAX;
      cfg_r.current_step <= RST_CURRENT_STEP;
      cfg_r.current_max  <= RST_CURRENT_MAX;
      cfg_r.long_press   <= RST_LONG_PRESS;
      cfg_r.save_delay   <= RST_SAVE_DELAY;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP_TRIP:    cfg_r.temp_trip    <= cfg_data[11:0];
        REG_TEMP_RECOVER: cfg_r.temp_recover <= cfg_data[11:0];
        REG_VOLTAGE_STEP: cfg_r.voltage_step <= cfg_data[9:0];
        REG_VOLTAGE_MAX:  cfg_r.voltage_max  <= cfg_data[15:0];
        REG_CURRENT_STEP: cfg_r.current_step <= cfg_data[9:0];
        REG_CURRENT_MAX:  cfg_r.current_max  <= cfg_data[15:0];
        REG_LONG_PRESS:   cfg_r.long_press   <= cfg_data[7:0];
        REG_SAVE_DELAY:   cfg_r.save_delay   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/pfpc_ctrl.sv
`timescale 1ns / 1ps

module pfpc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output pfpc_pkg::cmd_t     cmd
);
  import pfpc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_EDIT = 3'd2;
  localparam logic [2:0] S_DAC  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_r || out_tready;
  // a new tick may be taken in the same cycle the previous result is loaded
  assign in_tready  = rst_n && ((state_r == S_IDLE) || (state_r == S_OUT && out_free));
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.load_in  = accept;
    cmd.exec     = (state_r == S_EXEC);
    cmd.edit     = (state_r == S_EDIT);
    cmd.dac      = (state_r == S_DAC);
    cmd.out_load = (state_r == S_OUT) && out_free;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_EDIT;
      S_EDIT: state_nxt = S_DAC;
      S_DAC:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_EXEC)
    else $error("accepted tick did not start execution");

  a_ready_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE || state_r == S_OUT))
    else $error("input ready while a tick is in work");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_OUT)
    else $error("result raised outside the output state");

endmodule

>>> hdl/pfpc_dp.sv
`timescale 1ns / 1ps

module pfpc_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pfpc_pkg::cmd_t             cmd,
  input  pfpc_pkg::cfg_t             cfg,
  input  logic [pfpc_pkg::IN_W-1:0]  in_tdata,
  output logic [pfpc_pkg::OUT_W-1:0] out_tdata
);
  import pfpc_pkg::*;

  // latched tick
  logic               enc_r, mode_r;
  logic signed [9:0]  delta_r;
  logic [11:0]        temp_r;

  // panel state
  logic        standby_r, standby_nxt;
  logic [7:0]  long_count_r, long_count_nxt;
  logic        prev_enc_r, prev_enc_nxt;
  logic        prev_mode_r, prev_mode_nxt;
  logic        edit_cur_r, edit_cur_nxt;
  logic        output_on_r, output_on_nxt;
  logic [15:0] vset_r, iset_r;
  logic [4:0]  hold_r, hold_nxt;
  logic        over_temp_r, over_temp_nxt;
  logic [7:0]  save_r, save_nxt;
  logic [7:0]  flash_r, flash_nxt;

  // per-tick work registers
  logic               show_r, show_nxt;
  logic               green_r, green_nxt;
  logic               strobe_r, strobe_nxt;
  logic               do_edit_r, do_edit_nxt;
  logic signed [20:0] product_r;
  logic [29:0]        vprod_r;
  logic [30:0]        iprod_r;
  logic [OUT_W-1:0]   out_r;

  logic [9:0]         step_sel;
  logic [15:0]        base_sel, max_sel, edit_val;
  logic signed [21:0] sum;

  always_comb begin
    logic [7:0] lc;
    logic       entered;
    standby_nxt    = standby_r;
    long_count_nxt = long_count_r;
    edit_cur_nxt   = edit_cur_r;
    output_on_nxt  = output_on_r;
    hold_nxt       = hold_r;
    over_temp_nxt  = over_temp_r;
    save_nxt       = save_r;
    flash_nxt      = flash_r;
    show_nxt       = 1'b0;
    green_nxt      = 1'b0;
    strobe_nxt     = 1'b0;
    do_edit_nxt    = 1'b0;
    prev_enc_nxt   = enc_r;
    prev_mode_nxt  = mode_r;
    entered        = 1'b0;
    lc             = long_count_r + 8'd1;
    if (standby_r) begin
      // falling edge on either button wakes the panel
      if ((!enc_r && prev_enc_r) || (!mode_r && prev_mode_r)) begin
        standby_nxt    = 1'b0;
        long_count_nxt = 8'd0;
      end
    end else begin
      if (!enc_r) begin
        long_count_nxt = lc;
        if (lc >= cfg.long_press) begin
          standby_nxt    = 1'b1;
          long_count_nxt = 8'd0;
          output_on_nxt  = 1'b0;
          entered        = 1'b1;
        end
      end else begin
        // short press release: toggle, enabling refused while over-temp
        if (!prev_enc_r && long_count_r < cfg.long_press) begin
          output_on_nxt = output_on_r ? 1'b0 : !over_temp_r;
        end
        long_count_nxt = 8'd0;
      end
      if (!entered) begin
        if (!mode_r && prev_mode_r) edit_cur_nxt = !edit_cur_r;
        if (delta_r != 10'sd0) begin
          do_edit_nxt = 1'b1;
          save_nxt    = cfg.save_delay;
          if (output_on_nxt) hold_nxt = HOLD_TICKS;
        end
        if (hold_nxt != 5'd0) hold_nxt = hold_nxt - 5'd1;
        if (!over_temp_r && temp_r >= cfg.temp_trip) begin
          over_temp_nxt = 1'b1;
          output_on_nxt = 1'b0;
        end else if (over_temp_r && temp_r < cfg.temp_recover) begin
          over_temp_nxt = 1'b0;
        end
        if (save_nxt != 8'd0) begin
          save_nxt   = save_nxt - 8'd1;
          strobe_nxt = (save_nxt == 8'd0);
        end
        show_nxt  = !over_temp_nxt && (!output_on_nxt || hold_nxt != 5'd0);
        flash_nxt = flash_r + 8'd1;
        green_nxt = output_on_nxt && flash_nxt[FLASH_BIT];
      end
    end
  end

  assign step_sel = edit_cur_nxt ? cfg.current_step : cfg.voltage_step;
  assign base_sel = edit_cur_r ? iset_r : vset_r;
  assign max_sel  = edit_cur_r ? cfg.current_max : cfg.voltage_max;
  assign sum      = $signed({6'd0, base_sel}) + $signed({product_r[20], product_r});

  always_comb begin
    if (sum[21]) begin
      edit_val = 16'd0;
    end else if (sum[20:0] > {5'd0, max_sel}) begin
      edit_val = max_sel;
    end else begin
      edit_val = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      enc_r   <= in_tdata[0];
      mode_r  <= in_tdata[1];
      delta_r <= $signed(in_tdata[11:2]);
      temp_r  <= in_tdata[23:12];
    end
    if (cmd.exec) begin
      show_r    <= show_nxt;
      green_r   <= green_nxt;
      strobe_r  <= strobe_nxt;
      do_edit_r <= do_edit_nxt;
      product_r <= delta_r * $signed({1'b0, step_sel});
    end
    if (cmd.dac) begin
      vprod_r <= vset_r * VDAC_GAIN;
      iprod_r <= iset_r * IDAC_GAIN;
    end
    if (cmd.out_load) begin
      out_r <= {1'b0, strobe_r, green_r, standby_r, over_temp_r, show_r, edit_cur_r,
                iset_r, vset_r, dac_sat(iprod_r[30:16]),
                output_on_r ? dac_sat({1'b0, vprod_r[29:16]}) : 12'd0,
                output_on_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      standby_r    <= 1'b0;
      long_count_r <= 8'd0;
      prev_enc_r   <= 1'b1;
      prev_mode_r  <= 1'b1;
      edit_cur_r   <= 1'b0;
      output_on_r  <= 1'b0;
      vset_r       <= RST_VOLTAGE_SET;
      iset_r       <= RST_CURRENT_SET;
      hold_r       <= 5'd0;
      over_temp_r  <= 1'b0;
      save_r       <= 8'd0;
      flash_r      <= 8'd0;
    end else begin
      if (cmd.exec) begin
        standby_r    <= standby_nxt;
        long_count_r <= long_count_nxt;
        prev_enc_r   <= prev_enc_nxt;
        prev_mode_r  <= prev_mode_nxt;
        edit_cur_r   <= edit_cur_nxt;
        output_on_r  <= output_on_nxt;
        hold_r       <= hold_nxt;
        over_temp_r  <= over_temp_nxt;
        save_r       <= save_nxt;
        flash_r      <= flash_nxt;
      end
      if (cmd.edit && do_edit_r) begin
        if (edit_cur_r) begin
          iset_r <= edit_val;
        end else begin
          vset_r <= edit_val;
        end
      end
    end
  end

  assign out_tdata = out_r;

  a_standby_off: assert property (@(posedge clk) disable iff (!rst_n)
    standby_r |-> !output_on_r)
    else $error("output on while in standby");

  a_overtemp_off: assert property (@(posedge clk) disable iff (!rst_n)
    over_temp_r |-> !output_on_r)
    else $error("output on while over-temperature");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(standby_r) && $stable(flash_r) && $stable(save_r))
    else $error("panel state moved outside execution");

endmodule

>>> hdl/psu_front_panel_controller_unit.sv
`timescale 1ns / 1ps

// Front-panel controller of a bench supply, one transaction per 50 ms tick.
// in_tdata carries the button levels, encoder delta and temperature code; each
// accepted tick yields exactly one status transaction on out_tdata with the
// output switch, both DAC codes, setpoints, display and LED flags and the
// save strobe.
// cfg_* writes one of the eight panel registers by index; it is ready whenever
// reset is released and is to be used only while no tick is in work.
// Each accepted tick runs through the four-step sequencer in the controller
// (execute, setpoint edit, DAC multiply, output load), and the result is valid
// once the output load has registered it; the next tick is taken in the
// cycle its predecessor's result is loaded.
// When out_tready is low the result stays in the output register; the next
// tick is worked through and then waits in the sequencer, with in_tready low,
// until the output register frees.
// Reset (rst_n low, synchronous) restores the register defaults and the panel
// state: output off, voltage editing, 3300 mV / 100 mA, no standby.
module psu_front_panel_controller_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] enc_button_level, [1] mode_button_level, [11:2] enc_delta, [23:12] temp_code
  input  logic [pfpc_pkg::IN_W-1:0]       in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] output_enabled, [12:1] voltage_dac, [24:13] current_dac,
  // [40:25] voltage_setpoint_mv, [56:41] current_setpoint_ma, [57] editing_current,
  // [58] setpoint_shown, [59] over_temp_flag, [60] standby_flag, [61] leds_lit,
  // [62] save_strobe, [63] zero
  output logic [pfpc_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pfpc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  pfpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pfpc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
